// ----- rtl/ubse_pkg.sv -----
// Shared types and constants for the uniform B-spline evaluator.
// Used by every module under rtl except ubse_ram; depends on nothing.
`default_nettype none

package ubse_pkg;

   localparam int COEF_W        = 32;
   localparam int POS_W         = 32;
   localparam int SLOT_W        = 6;
   localparam int ORDER_W       = 2;
   localparam int KNOT_W        = 6;
   localparam int FRAC_W        = 30;
   localparam int BASIS_W       = 32;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int DEF_MAX_COEFS = 64;
   localparam int DEF_MAX_ORDER = 3;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DIVIDEND_W    = 68;
   localparam int QUOT_W        = 37;
   localparam int DIV_STEP_W    = 7;

   localparam logic [ORDER_W-1:0]   RST_SPLINE_ORDER   = 2'd3;
   localparam logic [KNOT_W-1:0]    RST_INTERIOR_KNOTS = 6'd0;
   localparam logic [POS_W-1:0]     RST_RANGE_START    = 32'd0;
   localparam logic [POS_W-1:0]     RST_RANGE_END      = 32'd65536;

   localparam logic OP_EVAL = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPLINE_ORDER   = 2'd0,
      CSR_INTERIOR_KNOTS = 2'd1,
      CSR_RANGE_START    = 2'd2,
      CSR_RANGE_END      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                     operation;
      logic signed [POS_W-1:0]  position;
      logic [SLOT_W-1:0]        coef_index;
      logic signed [COEF_W-1:0] coef_value;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] spline_value;
      logic                     in_range;
      logic [SLOT_W-1:0]        first_basis_index;
   } rsp_type;

   typedef struct packed {
      logic [ORDER_W-1:0]      spline_order;
      logic [KNOT_W-1:0]       interior_knots;
      logic signed [POS_W-1:0] range_start;
      logic signed [POS_W-1:0] range_end;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_EVAL,
      CMD_OUTSIDE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [31:0]       data;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [31:0]           divisor;
      logic [DIV_STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/ubse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ubse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/ubse_fifo.sv -----
// Short command queue between the front classifier and the back engine.
// Depends on ubse_pkg.
`default_nettype none

module ubse_fifo
   import ubse_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ubse_front.sv -----
// Input side: accepts request words and sorts them into load, evaluate
// or out-of-domain commands. Depends on ubse_pkg.
`default_nettype none

module ubse_front
   import ubse_pkg::*;
(
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   input  wire req_type req_data,
   output logic         req_ready,
   input  wire logic    queue_full,
   output logic         push,
   output cmd_type      push_data
);

   logic              outside;
   logic [POS_W:0]    offset;

   assign outside = (cfg.range_end <= cfg.range_start)
                  || (req_data.position < cfg.range_start)
                  || (req_data.position > cfg.range_end);
   assign offset  = {req_data.position[POS_W-1], req_data.position}
                  - {cfg.range_start[POS_W-1], cfg.range_start};

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_data.slot = req_data.coef_index;
      if (req_data.operation == OP_LOAD) begin
         push_data.kind = CMD_LOAD;
         push_data.data = req_data.coef_value;
      end else begin
         push_data.kind = outside ? CMD_OUTSIDE : CMD_EVAL;
         push_data.data = offset[POS_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ubse_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on ubse_pkg.
`default_nettype none

module ubse_div
   import ubse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [31:0]           div_ff;
   logic [31:0]           rem_ff;
   logic [QUOT_W-1:0]     quo_ff;
   logic [DIV_STEP_W-1:0] cnt_ff;
   logic                  busy_ff, done_ff;
   logic [32:0]           rem_sh;
   logic [33:0]           diff;
   logic                  ge;

   assign rem_sh = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, div_ff};
   assign ge     = !diff[33];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         dvd_ff  <= req.dividend;
         div_ff  <= req.divisor;
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= req.steps;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[31:0] : rem_sh[31:0];
         quo_ff  <= {quo_ff[QUOT_W-2:0], ge};
         dvd_ff  <= {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/ubse_back.sv -----
// Back engine: coefficient loads, interval search, de Boor basis recursion and weighted sum.
// Depends on ubse_pkg, ubse_div and ubse_ram.
`default_nettype none

module ubse_back
   import ubse_pkg::*;
#(
   parameter int MAX_COEFS = DEF_MAX_COEFS,
   parameter int MAX_ORDER = DEF_MAX_ORDER
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int OW  = $clog2(MAX_ORDER + 1);
   localparam int DW  = FRAC_W + OW;
   localparam int PW  = DW + BASIS_W;
   localparam int ZW  = PW + 1 - FRAC_W;
   localparam int AW  = $clog2(MAX_COEFS);
   localparam int IXW = ((AW > 7) ? AW : 7) + 1;
   localparam int NW  = DIVIDEND_W - FRAC_W;
   localparam int ACW = 2 * COEF_W + 1 + OW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_N, S_DIV_N, S_WAIT_N, S_STAGE, S_MUL_P, S_DIV_P, S_WAIT_P,
      S_MUL_M, S_DIV_M, S_WAIT_M, S_ACC_RD, S_ACC_MUL, S_ACC_ADD, S_ROUND, S_EMIT
   } state_type;

   state_type                 state_ff;
   logic [31:0]               d_ff;
   logic [31:0]               len_ff;
   logic [NW-1:0]             n_ff;
   logic [SLOT_W-1:0]         qi_ff;
   logic [FRAC_W:0]           w_ff;
   logic [OW-1:0]             k_ff, s_ff, r_ff;
   logic [BASIS_W-1:0]        basis_ff [MAX_ORDER + 1];
   logic [BASIS_W-1:0]        cur_ff, prev_ff, tp_ff;
   logic [PW-1:0]             term_prod_ff;
   logic signed [2*COEF_W:0]  acc_prod_ff;
   logic signed [ACW-1:0]     acc_ff;
   logic signed [COEF_W-1:0]  value_ff;
   logic                      in_range_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   logic [KNOT_W:0]           gp1, room;
   logic [OW-1:0]             k_cfg, kp, km, j;
   logic [OW:0]               dk;
   logic [DW-1:0]             dplus, dminus, term_d;
   logic [PW:0]               y;
   logic [ZW-1:0]             z;
   logic [IXW-1:0]            acc_idx, load_idx;
   logic                      acc_in_tab, load_in_tab;
   logic                      ram_wr_en;
   logic signed [COEF_W-1:0]  ram_rd_data;
   logic [KNOT_W:0]           q_int;
   logic                      over;
   logic signed [ACW-1:0]     rounded, shifted;
   logic [ACW-32:0]           top_bits;
   logic                      out_free;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   assign gp1   = {1'b0, cfg.interior_knots} + 1'b1;
   assign room  = gp1 - {1'b0, qi_ff};
   assign k_cfg = (32'(cfg.spline_order) > MAX_ORDER) ? OW'(MAX_ORDER)
                                                      : OW'(cfg.spline_order);
   assign j     = s_ff - r_ff;
   assign kp    = ((KNOT_W + 1)'(r_ff) < room) ? r_ff : OW'(room);
   assign km    = ((KNOT_W + 1)'(j) < (KNOT_W + 1)'(qi_ff)) ? j : OW'(qi_ff);
   assign dk    = (OW + 1)'(kp) + (OW + 1)'(km);
   assign dplus  = {kp, {FRAC_W{1'b0}}} - DW'(w_ff);
   assign dminus = DW'(w_ff) + {km, {FRAC_W{1'b0}}};
   assign term_d = (state_ff == S_MUL_P) ? dplus : dminus;
   assign y      = (PW + 1)'(term_prod_ff) + ((PW + 1)'(dk) << (FRAC_W - 1));
   assign z      = y[PW:FRAC_W];

   assign q_int = div_rsp.quotient[QUOT_W-1:FRAC_W];
   assign over  = (q_int >= gp1);

   assign acc_idx     = IXW'(qi_ff) + IXW'(r_ff);
   assign acc_in_tab  = (acc_idx < IXW'(MAX_COEFS));
   assign load_idx    = IXW'(cmd.slot);
   assign load_in_tab = (load_idx < IXW'(MAX_COEFS));

   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign ram_wr_en = cmd_pop && (cmd.kind == CMD_LOAD) && load_in_tab;

   assign rounded  = acc_ff + (ACW'(1) <<< (FRAC_W - 1));
   assign shifted  = rounded >>> FRAC_W;
   assign top_bits = shifted[ACW-1:31];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {z, {(DIVIDEND_W - ZW){1'b0}}};
      div_req.divisor  = 32'(dk);
      div_req.steps    = DIV_STEP_W'(ZW);
      case (state_ff)
         S_DIV_N: begin
            div_req.start    = 1'b1;
            div_req.dividend = {n_ff, {FRAC_W{1'b0}}};
            div_req.divisor  = len_ff;
            div_req.steps    = DIV_STEP_W'(DIVIDEND_W);
         end
         S_DIV_P, S_DIV_M: begin
            div_req.start = 1'b1;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   ubse_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ubse_ram #(
      .WIDTH (COEF_W),
      .DEPTH (MAX_COEFS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (load_idx[AW-1:0]),
      .wr_data (cmd.data),
      .rd_addr (acc_idx[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  d_ff <= cmd.data;
                  k_ff <= k_cfg;
                  case (cmd.kind)
                     CMD_EVAL: begin
                        state_ff <= S_MUL_N;
                     end
                     CMD_OUTSIDE: begin
                        value_ff    <= '0;
                        in_range_ff <= 1'b0;
                        qi_ff       <= '0;
                        state_ff    <= S_EMIT;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_MUL_N: begin
               n_ff     <= NW'(d_ff * gp1);
               len_ff   <= 32'(cfg.range_end - cfg.range_start);
               state_ff <= S_DIV_N;
            end
            S_DIV_N: begin
               state_ff <= S_WAIT_N;
            end
            S_WAIT_N: begin
               if (div_rsp.done) begin
                  qi_ff       <= over ? cfg.interior_knots : q_int[SLOT_W-1:0];
                  w_ff        <= {over, div_rsp.quotient[FRAC_W-1:0]};
                  basis_ff[0] <= BASIS_W'(1) << FRAC_W;
                  s_ff        <= OW'(1);
                  r_ff        <= '0;
                  acc_ff      <= '0;
                  state_ff    <= (k_ff == '0) ? S_ACC_RD : S_STAGE;
               end
            end
            S_STAGE: begin
               cur_ff         <= basis_ff[0];
               prev_ff        <= '0;
               basis_ff[s_ff] <= '0;
               r_ff           <= OW'(1);
               state_ff       <= S_MUL_P;
            end
            S_MUL_P, S_MUL_M: begin
               term_prod_ff <= term_d * cur_ff;
               state_ff     <= (state_ff == S_MUL_P) ? S_DIV_P : S_DIV_M;
            end
            S_DIV_P: begin
               state_ff <= S_WAIT_P;
            end
            S_WAIT_P: begin
               if (div_rsp.done) begin
                  tp_ff    <= div_rsp.quotient[BASIS_W-1:0];
                  state_ff <= S_MUL_M;
               end
            end
            S_DIV_M: begin
               state_ff <= S_WAIT_M;
            end
            S_WAIT_M: begin
               if (div_rsp.done) begin
                  basis_ff[OW'(r_ff - 1'b1)] <= prev_ff + tp_ff;
                  basis_ff[r_ff]             <= div_rsp.quotient[BASIS_W-1:0];
                  prev_ff                    <= div_rsp.quotient[BASIS_W-1:0];
                  cur_ff                     <= basis_ff[r_ff];
                  if (r_ff == s_ff) begin
                     if (s_ff == k_ff) begin
                        r_ff     <= '0;
                        state_ff <= S_ACC_RD;
                     end else begin
                        s_ff     <= s_ff + 1'b1;
                        state_ff <= S_STAGE;
                     end
                  end else begin
                     r_ff     <= r_ff + 1'b1;
                     state_ff <= S_MUL_P;
                  end
               end
            end
            S_ACC_RD: begin
               state_ff <= S_ACC_MUL;
            end
            S_ACC_MUL: begin
               if (acc_in_tab) begin
                  acc_prod_ff <= $signed({1'b0, basis_ff[r_ff]}) * ram_rd_data;
               end else begin
                  acc_prod_ff <= '0;
               end
               state_ff <= S_ACC_ADD;
            end
            S_ACC_ADD: begin
               acc_ff <= acc_ff + ACW'(acc_prod_ff);
               if (r_ff == k_ff) begin
                  state_ff <= S_ROUND;
               end else begin
                  r_ff     <= r_ff + 1'b1;
                  state_ff <= S_ACC_RD;
               end
            end
            S_ROUND: begin
               if ((&top_bits) || !(|top_bits)) begin
                  value_ff <= shifted[COEF_W-1:0];
               end else if (shifted[ACW-1]) begin
                  value_ff <= 32'sh8000_0000;
               end else begin
                  value_ff <= 32'sh7fff_ffff;
               end
               in_range_ff <= 1'b1;
               state_ff    <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff                  <= 1'b1;
                  rsp_data_ff.spline_value      <= value_ff;
                  rsp_data_ff.in_range          <= in_range_ff;
                  rsp_data_ff.first_basis_index <= qi_ff;
                  state_ff                      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/uniform_bspline_evaluator_unit.sv -----
// Uniform B-spline evaluator, top level: config registers, front, queue, back.
// Evaluate words are paced by the shared bit-serial divider.
// One word in the back engine at a time; the queue holds two more.
// Synchronous active-high reset clears control and config; coefficient RAM
// is not cleared.
`default_nettype none

module uniform_bspline_evaluator_unit
   import ubse_pkg::*;
#(
   parameter int MAX_COEFS = DEF_MAX_COEFS,
   parameter int MAX_ORDER = DEF_MAX_ORDER
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff;
   logic    queue_full, queue_empty, push, pop;
   cmd_type push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spline_order   <= RST_SPLINE_ORDER;
         cfg_ff.interior_knots <= RST_INTERIOR_KNOTS;
         cfg_ff.range_start    <= RST_RANGE_START;
         cfg_ff.range_end      <= RST_RANGE_END;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SPLINE_ORDER:   cfg_ff.spline_order   <= csr_data[ORDER_W-1:0];
            CSR_INTERIOR_KNOTS: cfg_ff.interior_knots <= csr_data[KNOT_W-1:0];
            CSR_RANGE_START:    cfg_ff.range_start    <= csr_data;
            CSR_RANGE_END:      cfg_ff.range_end      <= csr_data;
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   ubse_front u_front (
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_ready  (req_ready),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   ubse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   ubse_back #(
      .MAX_COEFS (MAX_COEFS),
      .MAX_ORDER (MAX_ORDER)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!queue_empty),
      .cmd       (pop_data),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for uniform_bspline_evaluator_unit: drives load and evaluate words,
// predicts each spline result in fixed point (or takes a given one) and compares it field by field.
// Depends on rtl/ubse_pkg.sv and rtl/uniform_bspline_evaluator_unit.sv.
`timescale 1ns / 100ps

module tb;
   import ubse_pkg::*;

   localparam longint CYCLE_LIMIT = 20000000;
   localparam int     DRAIN_CYCLES = 1200;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   logic [ORDER_W-1:0]      cur_order;
   logic [KNOT_W-1:0]       cur_knots;
   logic signed [POS_W-1:0] cur_start;
   logic signed [POS_W-1:0] cur_end;
   logic signed [COEF_W-1:0] coef_table [DEF_MAX_COEFS];

   rsp_type spline_due [$];
   int      error_count;
   int      words_out;
   int      hold_cycles;
   bit      steady;
   longint  cycle_count;

   uniform_bspline_evaluator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint knot_offset(longint q, longint g, longint m);
      longint t;
      t = q + m;
      if (t < 0) t = 0;
      if (t > g + 1) t = g + 1;
      return t - q;
   endfunction

   function automatic longint unsigned basis_term(longint unsigned d, longint unsigned n,
                                                  longint unsigned dk);
      return (d * n + (dk << 29)) / (dk << 30);
   endfunction

   function automatic longint sat_sum(longint acc, longint t);
      if (t > 0 && acc > 64'sh7FFF_FFFF_FFFF_FFFF - t) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (t < 0 && acc < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - t) return -64'sh7FFF_FFFF_FFFF_FFFF - 1;
      return acc + t;
   endfunction

   function automatic rsp_type spline_at(logic signed [POS_W-1:0] pos);
      rsp_type          r;
      longint unsigned  basis [4];
      longint unsigned  dplus [4];
      longint unsigned  dminus [4];
      longint unsigned  prod, quo, rem, w, prev, old, cur, dk, span;
      longint           k, g, qi, acc, v, a, b, x;
      a = cur_start;
      b = cur_end;
      x = pos;
      r = '0;
      if (b <= a || x < a || x > b) return r;
      k = (cur_order > DEF_MAX_ORDER) ? DEF_MAX_ORDER : cur_order;
      g = cur_knots;
      span = b - a;
      prod = longint'(x - a) * (g + 1);
      quo = prod / span;
      rem = prod % span;
      qi = (longint'(quo) > g) ? g : longint'(quo);
      w = ((quo - qi) << 30) + (rem << 30) / span;
      basis[0] = 64'd1 << 30;
      for (int s = 1; s <= k; s++) begin
         prev = 0;
         old = basis[0];
         dplus[s-1] = (longint'(knot_offset(qi, g, s)) << 30) - w;
         dminus[s-1] = w + (longint'(-knot_offset(qi, g, 1 - s)) << 30);
         basis[s] = 0;
         for (int j = 1; j <= s; j++) begin
            dk = knot_offset(qi, g, j) - knot_offset(qi, g, j - s);
            cur = old;
            old = basis[j];
            basis[j-1] = prev + basis_term(dplus[j-1], cur, dk);
            basis[j] = basis_term(dminus[s-j], cur, dk);
            prev = basis[j];
         end
      end
      acc = 0;
      for (int j = 0; j <= k; j++)
         if (qi + j < DEF_MAX_COEFS)
            acc = sat_sum(acc, longint'(basis[j]) * longint'(coef_table[qi + j]));
      acc = sat_sum(acc, longint'(1) << 29);
      v = acc >>> 30;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      r.spline_value = v[31:0];
      r.in_range = 1'b1;
      r.first_basis_index = qi[SLOT_W-1:0];
      return r;
   endfunction

   function automatic void note_word(stim_row_type row);
      if (row.req.operation == OP_LOAD)
         coef_table[row.req.coef_index] = row.req.coef_value;
      else if (row.known)
         spline_due.push_back(row.rsp);
      else
         spline_due.push_back(spline_at(row.req.position));
   endfunction

   task automatic send_word(stim_row_type row);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= row.req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      note_word(row);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_SPLINE_ORDER:   cur_order = value[ORDER_W-1:0];
         CSR_INTERIOR_KNOTS: cur_knots = value[KNOT_W-1:0];
         CSR_RANGE_START:    cur_start = value;
         CSR_RANGE_END:      cur_end = value;
         default:            cur_order = cur_order;
      endcase
   endtask

   task automatic set_spline(logic [ORDER_W-1:0] order, logic [KNOT_W-1:0] knots,
                             logic [31:0] lo, logic [31:0] hi);
      req_valid <= 1'b0;
      while (spline_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(CSR_SPLINE_ORDER, {$urandom_range(0, 1) ? 30'($urandom) : 30'd0, order});
      write_csr(CSR_INTERIOR_KNOTS, {$urandom_range(0, 1) ? 26'($urandom) : 26'd0, knots});
      write_csr(CSR_RANGE_START, lo);
      write_csr(CSR_RANGE_END, hi);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic stim_row_type random_word();
      stim_row_type    row;
      longint          span;
      longint unsigned pick;
      int              sel;
      row.known = 1'b0;
      row.rsp = '0;
      row.req.operation = OP_EVAL;
      row.req.position = $urandom;
      row.req.coef_index = $urandom_range(0, DEF_MAX_COEFS - 1);
      row.req.coef_value = $urandom;
      sel = $urandom_range(0, 99);
      span = longint'(cur_end) - longint'(cur_start);
      if (sel < 12) begin
         row.req.operation = OP_LOAD;
         if ($urandom_range(0, 3) == 0)
            row.req.coef_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else if (sel < 20) begin
         row.req.position = $urandom_range(0, 1) ? cur_start : cur_end;
      end else if (sel < 26) begin
         row.req.position = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else if (sel < 90 && span > 0) begin
         pick = {$urandom, $urandom};
         row.req.position = 32'(longint'(cur_start) + longint'(pick % (span + 1)));
      end
      return row;
   endfunction

   task automatic run_phase(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
         send_word(random_word());
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cycles <= 1;
         words_out <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (spline_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %p", $time, rsp_data);
               error_count++;
            end else begin
               if (rsp_data.spline_value !== spline_due[0].spline_value) begin
                  $display("%0t: spline_value expected %h actual %h", $time,
                           spline_due[0].spline_value, rsp_data.spline_value);
                  error_count++;
               end
               if (rsp_data.in_range !== spline_due[0].in_range) begin
                  $display("%0t: in_range expected %b actual %b", $time,
                           spline_due[0].in_range, rsp_data.in_range);
                  error_count++;
               end
               if (rsp_data.first_basis_index !== spline_due[0].first_basis_index) begin
                  $display("%0t: first_basis_index expected %0d actual %0d", $time,
                           spline_due[0].first_basis_index, rsp_data.first_basis_index);
                  error_count++;
               end
               void'(spline_due.pop_front());
            end
            words_out <= words_out + 1;
            if (words_out == 40) begin
               hold_cycles <= 4000;
               rsp_ready <= 1'b0;
            end else if (steady || $urandom_range(0, 5) == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               hold_cycles <= $urandom_range(1, 5);
               rsp_ready <= 1'b0;
            end
         end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= (hold_cycles == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      stim_row_type steps [$];
      stim_row_type row;
      error_count = 0;
      cycle_count = 0;
      steady = 1'b0;
      cur_order = RST_SPLINE_ORDER;
      cur_knots = RST_INTERIOR_KNOTS;
      cur_start = RST_RANGE_START;
      cur_end = RST_RANGE_END;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_SPLINE_ORDER;
      csr_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill every slot before any evaluate can read it
      for (int i = 0; i < DEF_MAX_COEFS; i++) begin
         row.known = 1'b0;
         row.rsp = '0;
         row.req = '{OP_LOAD, 32'($urandom), 6'(i), 32'($urandom)};
         send_word(row);
      end

      steps = '{
         '{'{OP_LOAD, 32'h0, 6'd0, 32'h7FFF_FFFF}, 1'b0, '0},
         '{'{OP_LOAD, 32'h0, 6'd1, 32'h8000_0000}, 1'b0, '0},
         '{'{OP_LOAD, 32'hFFFF_FFFF, 6'd2, 32'd12345}, 1'b0, '0},
         '{'{OP_LOAD, 32'h0, 6'd3, 32'hFFFF_FFFF}, 1'b0, '0},
         '{'{OP_EVAL, 32'h0, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, 1'b1, 6'd0}},
         '{'{OP_EVAL, 32'd65536, 6'd0, 32'h0}, 1'b1, '{32'hFFFF_FFFF, 1'b1, 6'd0}},
         '{'{OP_EVAL, 32'hFFFF_FFFF, 6'd0, 32'h0}, 1'b1, '{32'h0, 1'b0, 6'd0}},
         '{'{OP_EVAL, 32'd65537, 6'd0, 32'h0}, 1'b1, '{32'h0, 1'b0, 6'd0}},
         '{'{OP_EVAL, 32'h7FFF_FFFF, 6'd0, 32'h0}, 1'b1, '{32'h0, 1'b0, 6'd0}},
         '{'{OP_EVAL, 32'h8000_0000, 6'd0, 32'h0}, 1'b1, '{32'h0, 1'b0, 6'd0}},
         '{'{OP_EVAL, 32'd32768, 6'd0, 32'h0}, 1'b0, '0},
         '{'{OP_EVAL, 32'd1, 6'd0, 32'h0}, 1'b0, '0},
         '{'{OP_EVAL, 32'd65535, 6'd0, 32'h0}, 1'b0, '0},
         '{'{OP_LOAD, 32'h0, 6'd1, 32'h7FFF_FFFF}, 1'b0, '0},
         '{'{OP_LOAD, 32'h0, 6'd2, 32'h7FFF_FFFF}, 1'b0, '0},
         '{'{OP_LOAD, 32'h0, 6'd3, 32'h7FFF_FFFF}, 1'b0, '0},
         '{'{OP_EVAL, 32'd21845, 6'd0, 32'h0}, 1'b0, '0},
         '{'{OP_EVAL, 32'd43690, 6'd0, 32'h0}, 1'b0, '0},
         '{'{OP_LOAD, 32'h0, 6'd63, 32'h8000_0000}, 1'b0, '0}
      };
      foreach (steps[i]) send_word(steps[i]);

      set_spline(2'd3, 6'd60, 32'h8000_0000, 32'h7FFF_FFFF);
      run_phase(260);
      set_spline(2'd0, 6'd5, -32'sd65536, 32'sd65536);
      run_phase(260);
      set_spline(2'd1, 6'd0, 32'd100, 32'd101);
      run_phase(200);
      set_spline(2'd2, 6'($urandom_range(1, 60)), -32'sd300000 - 32'($urandom_range(0, 9999)),
                 32'sd300000 + 32'($urandom_range(0, 99999)));
      run_phase(260);
      set_spline(2'd3, 6'd60, 32'd0, 32'd60);
      run_phase(240);
      set_spline(2'd3, 6'd7, 32'd1000, 32'd1000);
      run_phase(60);
      set_spline(2'd1, 6'd9, 32'd5000, 32'hFFFF_0000);
      run_phase(60);
      set_spline(2'd3, 6'd3, -32'sd40000, 32'sd40000);
      run_phase(280);
      set_spline(2'd2, 6'd60, 32'h8000_0000, 32'h7FFF_FFFF);
      run_phase(280);
      req_valid <= 1'b0;

      while (spline_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- uniform_bspline_evaluator_unit.f -----
rtl/ubse_pkg.sv
rtl/ubse_ram.sv
rtl/ubse_fifo.sv
rtl/ubse_front.sv
rtl/ubse_div.sv
rtl/ubse_back.sv
rtl/uniform_bspline_evaluator_unit.sv
bench/tb.sv
